// ===== rtl/pssc_pkg.sv =====
// Shared types and constants for the packet statistics block.
package pssc_pkg;
   localparam int CacheDepth = 16;
   localparam int IdxW = $clog2(CacheDepth);
   localparam int KeyW = 62;
   localparam int ChgW = 47;
   localparam int CntW = 63;
   localparam logic [CntW-1:0] WrapAt = {CntW{1'b1}};

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_CMD = 2'd1,
      KIND_TIMING = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CLS_NEUTRON = 3'd0,
      CLS_META = 3'd1,
      CLS_CMD = 3'd2,
      CLS_TIMING = 3'd3,
      CLS_ERROR = 3'd4
   } class_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_UPDATE = 2'd1
   } state_type;

   // per-cell entry of a stamp cache
   typedef struct packed {
      logic valid;
      logic [KeyW-1:0] key;
      logic known;
      logic used;
      logic [ChgW-1:0] charge;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic shift;
      logic [IdxW:0] keep;
      logic attach;
      logic [IdxW-1:0] attach_at;
      logic mark_used;
      logic [IdxW-1:0] used_at;
   } cell_ctl_type;

   function automatic logic [CntW-1:0] wrap_add(logic [CntW-1:0] a, logic [CntW-1:0] b);
      logic [CntW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, WrapAt}) s = s - {1'b0, WrapAt};
      return s[CntW-1:0];
   endfunction
endpackage

// ===== rtl/packet_stats_with_stamp_cache.sv =====
// The result is on the ports in the cycle after the update cycle.
// Items are handled one at a time (input capture, then lookup and cache update); busy is high during the update.
// The three caches are rows of sixteen cells compared in parallel.
// Reset: synchronous; caches emptied, counters zeroed, cache_size back to 10.
// Results cannot be stalled by the receiver.
module packet_stats_with_stamp_cache (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_kind,
   input  logic [15:0] req_packet_length,
   input  logic [15:0] req_event_count,
   input  logic [7:0] req_event_size,
   input  logic req_meta_format,
   input  logic [31:0] req_stamp_sec,
   input  logic [29:0] req_stamp_nsec,
   input  logic signed [47:0] req_proton_charge,
   input  logic csr_we,
   input  logic [4:0] csr_wdata,
   output logic rsp_valid,
   output logic [2:0] rsp_stat_class,
   output logic [62:0] rsp_class_count,
   output logic [62:0] rsp_class_bytes,
   output logic [62:0] rsp_class_unique_times,
   output logic [62:0] rsp_total_bytes,
   output logic rsp_charge_valid,
   output logic [46:0] rsp_charge_out
);
   import pssc_pkg::*;
   typedef enum logic [3:0] {
      C_NCNT, C_NBYTES, C_NTIMES, C_MCNT, C_MBYTES, C_MTIMES, C_CMDPKTS,
      C_CMDBYTES, C_ERRPKTS, C_RPKTS, C_RBYTES, C_RTIMES, C_TOTBYTES
   } ctr_type;
   localparam int NumCtr = 13;

   state_type state_ff, state_in;
   logic [4:0] size_ff;
   logic [CntW-1:0] ctr_ff [NumCtr];
   kind_type kind_ff;
   logic [15:0] len_ff;
   logic [23:0] bytes_ff;
   logic [15:0] nev_ff;
   logic meta_ff;
   logic [KeyW-1:0] key_ff;
   logic [ChgW-1:0] chg_ff;
   logic rsp_valid_ff;
   logic [2:0] cls_ff;
   logic [CntW-1:0] o_cnt_ff, o_byt_ff, o_uni_ff, o_tot_ff;
   logic o_cv_ff;
   logic [ChgW-1:0] o_chg_ff;

   cell_ctl_type ctl_n, ctl_m, ctl_t;
   logic n_found, m_found, t_found, n_nx, m_nx, t_nx;
   logic [IdxW-1:0] n_at, m_at, t_at;
   logic n_k, n_u, m_k, m_u, t_k, t_u;
   logic [ChgW-1:0] n_c, m_c, t_c;
   logic [IdxW:0] n_fill, m_fill, t_fill, eff;
   logic upd;

   assign upd = state_ff == ST_UPDATE;
   assign busy = state_ff != ST_IDLE;

   always_comb begin
      if (size_ff == 5'd0) eff = (IdxW+1)'(1);
      else if ({1'b0, size_ff} > 6'(CacheDepth)) eff = (IdxW+1)'(CacheDepth);
      else eff = (IdxW+1)'(size_ff);
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = start ? ST_UPDATE : ST_IDLE;
         ST_UPDATE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // the timing lookup for a new stamp sees an entry with unknown charge
   logic is_data, is_tim, t_hit_new, cv;
   always_comb begin
      is_data = kind_ff == KIND_DATA;
      is_tim = kind_ff == KIND_TIMING;
      ctl_n = '0; ctl_m = '0; ctl_t = '0;
      ctl_n.keep = eff; ctl_m.keep = eff; ctl_t.keep = eff - 1'b1;
      ctl_n.shift = upd && is_data && !meta_ff && !n_found;
      ctl_m.shift = upd && is_data && meta_ff && !m_found;
      ctl_t.shift = upd && is_tim && !t_found;
      ctl_t.attach = upd && is_tim && t_found && t_nx;
      ctl_t.attach_at = t_at + 1'b1;
      t_hit_new = t_found && t_k && !t_u && !(is_tim && t_nx && (t_at == IdxW'(0) - 1'b1));
      cv = (is_data || is_tim) && t_found && t_k && !t_u;
      ctl_t.mark_used = upd && cv;
      ctl_t.used_at = t_at;
   end

   pssc_chain u_n (.clock(clock), .reset(reset), .ctl(ctl_n), .key(key_ff),
      .attach_charge(chg_ff), .found(n_found), .found_at(n_at), .found_next(n_nx),
      .found_known(n_k), .found_used(n_u), .found_charge(n_c), .fill(n_fill));
   pssc_chain u_m (.clock(clock), .reset(reset), .ctl(ctl_m), .key(key_ff),
      .attach_charge(chg_ff), .found(m_found), .found_at(m_at), .found_next(m_nx),
      .found_known(m_k), .found_used(m_u), .found_charge(m_c), .fill(m_fill));
   pssc_chain u_t (.clock(clock), .reset(reset), .ctl(ctl_t), .key(key_ff),
      .attach_charge(chg_ff), .found(t_found), .found_at(t_at), .found_next(t_nx),
      .found_known(t_k), .found_used(t_u), .found_charge(t_c), .fill(t_fill));

   logic [CntW-1:0] nc [NumCtr];
   always_comb begin
      for (int i = 0; i < NumCtr; i++) nc[i] = ctr_ff[i];
      nc[C_TOTBYTES] = wrap_add(ctr_ff[C_TOTBYTES], CntW'(len_ff));
      unique case (kind_ff)
         KIND_DATA: begin
            if (meta_ff) begin
               nc[C_MBYTES] = wrap_add(ctr_ff[C_MBYTES], CntW'(bytes_ff));
               nc[C_MCNT] = wrap_add(ctr_ff[C_MCNT], CntW'(nev_ff));
               if (!m_found) nc[C_MTIMES] = wrap_add(ctr_ff[C_MTIMES], CntW'(1));
            end else begin
               nc[C_NBYTES] = wrap_add(ctr_ff[C_NBYTES], CntW'(bytes_ff));
               nc[C_NCNT] = wrap_add(ctr_ff[C_NCNT], CntW'(nev_ff));
               if (!n_found) nc[C_NTIMES] = wrap_add(ctr_ff[C_NTIMES], CntW'(1));
            end
         end
         KIND_CMD: begin
            nc[C_CMDPKTS] = wrap_add(ctr_ff[C_CMDPKTS], CntW'(1));
            nc[C_CMDBYTES] = wrap_add(ctr_ff[C_CMDBYTES], CntW'(len_ff));
         end
         KIND_TIMING: begin
            nc[C_RPKTS] = wrap_add(ctr_ff[C_RPKTS], CntW'(1));
            nc[C_RBYTES] = wrap_add(ctr_ff[C_RBYTES], CntW'(len_ff));
            if (!t_found) nc[C_RTIMES] = wrap_add(ctr_ff[C_RTIMES], CntW'(1));
         end
         default: nc[C_ERRPKTS] = wrap_add(ctr_ff[C_ERRPKTS], CntW'(1));
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         size_ff <= 5'd10;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NumCtr; i++) ctr_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) size_ff <= csr_wdata;
         rsp_valid_ff <= upd;
         if (upd) for (int i = 0; i < NumCtr; i++) ctr_ff[i] <= nc[i];
      end
      if (start && !busy) begin
         kind_ff <= kind_type'(req_kind);
         len_ff <= req_packet_length;
         bytes_ff <= 24'(req_event_count) * 24'(req_event_size);
         nev_ff <= req_event_count;
         meta_ff <= req_meta_format;
         key_ff <= {req_stamp_sec, req_stamp_nsec};
         chg_ff <= req_proton_charge[47] ? '0 : req_proton_charge[ChgW-1:0];
      end
      if (upd) begin
         o_tot_ff <= nc[C_TOTBYTES];
         o_cv_ff <= cv;
         o_chg_ff <= cv ? t_c : '0;
         unique case (kind_ff)
            KIND_DATA: begin
               cls_ff <= meta_ff ? CLS_META : CLS_NEUTRON;
               o_cnt_ff <= meta_ff ? nc[C_MCNT] : nc[C_NCNT];
               o_byt_ff <= meta_ff ? nc[C_MBYTES] : nc[C_NBYTES];
               o_uni_ff <= meta_ff ? nc[C_MTIMES] : nc[C_NTIMES];
            end
            KIND_CMD: begin
               cls_ff <= CLS_CMD;
               o_cnt_ff <= nc[C_CMDPKTS];
               o_byt_ff <= nc[C_CMDBYTES];
               o_uni_ff <= '0;
            end
            KIND_TIMING: begin
               cls_ff <= CLS_TIMING;
               o_cnt_ff <= nc[C_RPKTS];
               o_byt_ff <= nc[C_RBYTES];
               o_uni_ff <= nc[C_RTIMES];
            end
            default: begin
               cls_ff <= CLS_ERROR;
               o_cnt_ff <= nc[C_ERRPKTS];
               o_byt_ff <= '0;
               o_uni_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_stat_class = cls_ff;
   assign rsp_class_count = o_cnt_ff;
   assign rsp_class_bytes = o_byt_ff;
   assign rsp_class_unique_times = o_uni_ff;
   assign rsp_total_bytes = o_tot_ff;
   assign rsp_charge_valid = o_cv_ff;
   assign rsp_charge_out = o_chg_ff;

   logic unused_ok;
   assign unused_ok = ^{n_at, m_at, n_nx, m_nx, n_k, n_u, m_k, m_u, n_c, m_c,
                        n_fill, m_fill, t_fill, t_hit_new};

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_UPDATE) else $error("stray result");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      n_fill <= (IdxW+1)'(CacheDepth) && t_fill < (IdxW+1)'(CacheDepth))
      else $error("cache overfill");
   a_charge_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_charge_valid |-> rsp_charge_out == '0) else $error("charge leak");
endmodule

// ===== rtl/pssc_cell.sv =====
// One cache cell: holds an entry, compares it and hands it to the older neighbour.
module pssc_cell (
   input  logic clock,
   input  logic reset,
   input  logic [pssc_pkg::IdxW-1:0] pos,
   input  pssc_pkg::entry_type newer,
   input  pssc_pkg::cell_ctl_type ctl,
   input  logic [pssc_pkg::ChgW-1:0] attach_charge,
   input  logic [pssc_pkg::KeyW-1:0] key,
   output pssc_pkg::entry_type entry,
   output logic hit
);
   import pssc_pkg::*;
   entry_type ent_ff, ent_in;
   logic [IdxW:0] pos_w;

   assign pos_w = {1'b0, pos};
   assign entry = ent_ff;
   assign hit = ent_ff.valid && ent_ff.key == key;

   always_comb begin
      ent_in = ent_ff;
      if (ctl.shift) begin
         ent_in = newer;
         if (pos_w >= ctl.keep) ent_in.valid = 1'b0;
      end else begin
         if (ctl.attach && ctl.attach_at == pos) begin
            ent_in.charge = attach_charge;
            ent_in.known = 1'b1;
         end
         if (ctl.mark_used && ctl.used_at == pos) ent_in.used = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
         ent_ff.known <= 1'b0;
         ent_ff.used <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
         ent_ff.known <= ent_in.known;
         ent_ff.used <= ent_in.used;
      end
      ent_ff.key <= ent_in.key;
      ent_ff.charge <= ent_in.charge;
   end
endmodule

// ===== rtl/pssc_chain.sv =====
// Row of cache cells with head insertion and a hit position search.
module pssc_chain (
   input  logic clock,
   input  logic reset,
   input  pssc_pkg::cell_ctl_type ctl,
   input  logic [pssc_pkg::KeyW-1:0] key,
   input  logic [pssc_pkg::ChgW-1:0] attach_charge,
   output logic found,
   output logic [pssc_pkg::IdxW-1:0] found_at,
   output logic found_next,
   output logic found_known,
   output logic found_used,
   output logic [pssc_pkg::ChgW-1:0] found_charge,
   output logic [pssc_pkg::IdxW:0] fill
);
   import pssc_pkg::*;
   entry_type ents [CacheDepth];
   logic [CacheDepth-1:0] hits;
   entry_type head;

   always_comb begin
      head = '0;
      head.valid = 1'b1;
      head.key = key;
   end

   for (genvar g = 0; g < CacheDepth; g++) begin : g_cell
      pssc_cell u_cell (
         .clock(clock), .reset(reset), .pos(IdxW'(g)),
         .newer(g == 0 ? head : ents[(g == 0) ? 0 : g-1]),
         .ctl(ctl), .attach_charge(attach_charge), .key(key),
         .entry(ents[g]), .hit(hits[g]));
   end

   // valid bits form a prefix, so the first hit is the only one
   always_comb begin
      found = 1'b0;
      found_at = '0;
      fill = '0;
      for (int i = CacheDepth-1; i >= 0; i--) begin
         if (hits[i]) begin
            found = 1'b1;
            found_at = IdxW'(i);
         end
      end
      for (int i = 0; i < CacheDepth; i++) if (ents[i].valid) fill = (IdxW+1)'(i+1);
      found_known = ents[found_at].known;
      found_used = ents[found_at].used;
      found_charge = ents[found_at].charge;
      found_next = ({1'b0, found_at} + 1'b1) < fill;
   end
endmodule

// ===== tb/sv/packet_stats_with_stamp_cache_test.sv =====
// Self-checking testbench for the packet statistics block with timestamp caches.
module packet_stats_with_stamp_cache_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pssc_pkg::*;

   localparam logic [63:0] WRAP_POINT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef enum int {
      CNT_NEUTRON, BYTES_NEUTRON, TIMES_NEUTRON, CNT_META, BYTES_META, TIMES_META,
      PKTS_CMD, BYTES_CMD, PKTS_ERROR, PKTS_TIMING, BYTES_TIMING, TIMES_TIMING,
      BYTES_TOTAL, NUM_COUNTERS
   } counter_index_type;

   typedef struct {
      class_type cls;
      logic [62:0] count;
      logic [62:0] bytes;
      logic [62:0] unique_times;
      logic [62:0] total;
      logic charge_valid;
      logic [46:0] charge;
   } stats_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_kind = '0;
   logic [15:0] req_packet_length = '0;
   logic [15:0] req_event_count = '0;
   logic [7:0] req_event_size = '0;
   logic req_meta_format = 1'b0;
   logic [31:0] req_stamp_sec = '0;
   logic [29:0] req_stamp_nsec = '0;
   logic signed [47:0] req_proton_charge = '0;
   logic csr_we = 1'b0;
   logic [4:0] csr_wdata = '0;
   logic rsp_valid;
   logic [2:0] rsp_stat_class;
   logic [62:0] rsp_class_count;
   logic [62:0] rsp_class_bytes;
   logic [62:0] rsp_class_unique_times;
   logic [62:0] rsp_total_bytes;
   logic rsp_charge_valid;
   logic [46:0] rsp_charge_out;

   packet_stats_with_stamp_cache dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_packet_length(req_packet_length),
      .req_event_count(req_event_count), .req_event_size(req_event_size),
      .req_meta_format(req_meta_format), .req_stamp_sec(req_stamp_sec),
      .req_stamp_nsec(req_stamp_nsec), .req_proton_charge(req_proton_charge),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_stat_class(rsp_stat_class),
      .rsp_class_count(rsp_class_count), .rsp_class_bytes(rsp_class_bytes),
      .rsp_class_unique_times(rsp_class_unique_times),
      .rsp_total_bytes(rsp_total_bytes), .rsp_charge_valid(rsp_charge_valid),
      .rsp_charge_out(rsp_charge_out)
   );

   // mirror of the block's state
   logic [4:0] cache_size_reg = 5'd10;
   logic [61:0] data_keys [2][CacheDepth];
   int data_fill [2] = '{0, 0};
   logic [61:0] timing_keys [CacheDepth];
   logic [46:0] timing_charge [CacheDepth];
   logic timing_known [CacheDepth];
   logic timing_used [CacheDepth];
   int timing_fill = 0;
   logic [62:0] counters [NUM_COUNTERS];

   stats_result_type expected_stats [$];
   int mismatches = 0;
   int idle_pct = 0;
   logic [31:0] sec_pool [8];
   logic [29:0] nsec_pool [8];

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int eff_size();
      if (cache_size_reg < 1) return 1;
      if (cache_size_reg > CacheDepth) return CacheDepth;
      return int'(cache_size_reg);
   endfunction

   task automatic bump(counter_index_type which, logic [63:0] amount);
      logic [63:0] s;
      s = {1'b0, counters[which]} + amount;
      if (s >= WRAP_POINT) s = s - WRAP_POINT;
      counters[which] = s[62:0];
   endtask

   task automatic data_unique(int sel, logic [61:0] key, output bit fresh);
      int n;
      n = data_fill[sel];
      fresh = 1'b1;
      for (int i = 0; i < n && i < CacheDepth; i++)
         if (data_keys[sel][i] == key) fresh = 1'b0;
      if (fresh) begin
         if (n > eff_size() - 1) n = eff_size() - 1;
         for (int i = n; i > 0; i--) data_keys[sel][i] = data_keys[sel][i-1];
         data_keys[sel][0] = key;
         data_fill[sel] = n + 1;
      end
   endtask

   task automatic timing_insert(logic [61:0] key, logic [46:0] chg, output bit fresh);
      int n;
      n = timing_fill;
      for (int i = 0; i < n && i < CacheDepth; i++) begin
         if (timing_keys[i] == key) begin
            // a repeated stamp hands its charge to the next older entry
            if (i + 1 < n && i + 1 < CacheDepth) begin
               timing_charge[i+1] = chg;
               timing_known[i+1] = 1'b1;
            end
            fresh = 1'b0;
            return;
         end
      end
      fresh = 1'b1;
      if (n > CacheDepth - 1) n = CacheDepth - 1;
      for (int i = n; i > 0; i--) begin
         timing_keys[i] = timing_keys[i-1];
         timing_charge[i] = timing_charge[i-1];
         timing_known[i] = timing_known[i-1];
         timing_used[i] = timing_used[i-1];
      end
      timing_keys[0] = key;
      timing_charge[0] = '0;
      timing_known[0] = 1'b0;
      timing_used[0] = 1'b0;
      n = n + 1;
      if (n > eff_size() - 1) n = eff_size() - 1;
      timing_fill = n;
   endtask

   task automatic charge_lookup(logic [61:0] key, output bit hit, output logic [46:0] chg);
      hit = 1'b0;
      chg = '0;
      for (int i = 0; i < timing_fill && i < CacheDepth; i++) begin
         if (timing_keys[i] == key) begin
            if (timing_known[i] && !timing_used[i]) begin
               timing_used[i] = 1'b1;
               hit = 1'b1;
               chg = timing_charge[i];
            end
            return;
         end
      end
   endtask

   task automatic predict_stats();
      stats_result_type r;
      logic [61:0] key;
      logic [63:0] payload;
      bit fresh;
      key = {req_stamp_sec, req_stamp_nsec};
      payload = 64'(req_event_count) * 64'(req_event_size);
      r.charge_valid = 1'b0;
      r.charge = '0;
      bump(BYTES_TOTAL, 64'(req_packet_length));
      case (kind_type'(req_kind))
         KIND_DATA: begin
            if (req_meta_format) begin
               bump(BYTES_META, payload);
               bump(CNT_META, 64'(req_event_count));
               data_unique(1, key, fresh);
               if (fresh) bump(TIMES_META, 64'd1);
               r.cls = CLS_META;
               r.count = counters[CNT_META];
               r.bytes = counters[BYTES_META];
               r.unique_times = counters[TIMES_META];
            end else begin
               bump(BYTES_NEUTRON, payload);
               bump(CNT_NEUTRON, 64'(req_event_count));
               data_unique(0, key, fresh);
               if (fresh) bump(TIMES_NEUTRON, 64'd1);
               r.cls = CLS_NEUTRON;
               r.count = counters[CNT_NEUTRON];
               r.bytes = counters[BYTES_NEUTRON];
               r.unique_times = counters[TIMES_NEUTRON];
            end
            charge_lookup(key, fresh, r.charge);
            r.charge_valid = fresh;
         end
         KIND_CMD: begin
            bump(PKTS_CMD, 64'd1);
            bump(BYTES_CMD, 64'(req_packet_length));
            r.cls = CLS_CMD;
            r.count = counters[PKTS_CMD];
            r.bytes = counters[BYTES_CMD];
            r.unique_times = '0;
         end
         KIND_TIMING: begin
            bump(PKTS_TIMING, 64'd1);
            bump(BYTES_TIMING, 64'(req_packet_length));
            // negative charge clamps to zero
            timing_insert(key, req_proton_charge[47] ? 47'd0 : req_proton_charge[46:0], fresh);
            if (fresh) bump(TIMES_TIMING, 64'd1);
            charge_lookup(key, fresh, r.charge);
            r.charge_valid = fresh;
            r.cls = CLS_TIMING;
            r.count = counters[PKTS_TIMING];
            r.bytes = counters[BYTES_TIMING];
            r.unique_times = counters[TIMES_TIMING];
         end
         default: begin
            bump(PKTS_ERROR, 64'd1);
            r.cls = CLS_ERROR;
            r.count = counters[PKTS_ERROR];
            r.bytes = '0;
            r.unique_times = '0;
         end
      endcase
      r.total = counters[BYTES_TOTAL];
      expected_stats.push_back(r);
   endtask

   task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         if (mismatches < 10)
            $display("%0t: %s mismatch, expected %0h got %0h", $realtime, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      stats_result_type e;
      if (!reset && rsp_valid) begin
         if (expected_stats.size() == 0) begin
            if (mismatches < 10) $display("%0t: result with no item outstanding", $realtime);
            mismatches++;
         end else begin
            e = expected_stats.pop_front();
            check_field("stat_class", 64'(e.cls), 64'(rsp_stat_class));
            check_field("class_count", 64'(e.count), 64'(rsp_class_count));
            check_field("class_bytes", 64'(e.bytes), 64'(rsp_class_bytes));
            check_field("class_unique_times", 64'(e.unique_times),
                        64'(rsp_class_unique_times));
            check_field("total_bytes", 64'(e.total), 64'(rsp_total_bytes));
            check_field("charge_valid", 64'(e.charge_valid), 64'(rsp_charge_valid));
            check_field("charge_out", 64'(e.charge), 64'(rsp_charge_out));
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   task automatic send_item(kind_type kind, logic [15:0] len, logic [15:0] nev,
                            logic [7:0] esz, logic meta, logic [31:0] sec,
                            logic [29:0] nsec, logic [47:0] charge);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_kind = kind;
      req_packet_length = len;
      req_event_count = nev;
      req_event_size = esz;
      req_meta_format = meta;
      req_stamp_sec = sec;
      req_stamp_nsec = nsec;
      req_proton_charge = charge;
      do @(posedge clock); while (busy);
      predict_stats();
   endtask

   // lower start, then wait until every outstanding result has been checked
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (expected_stats.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_cache_size(logic [4:0] value);
      drain();
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      cache_size_reg = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic refill_stamp_pool();
      for (int i = 0; i < 8; i++) begin
         sec_pool[i] = $urandom;
         nsec_pool[i] = 30'($urandom);
      end
   endtask

   task automatic send_random_item();
      logic [31:0] sec;
      logic [29:0] nsec;
      int pick;
      kind_type kind;
      pick = $urandom_range(7);
      sec = sec_pool[pick];
      nsec = nsec_pool[pick];
      if ($urandom_range(9) == 0) begin
         sec = $urandom;
         nsec = 30'($urandom);
      end
      case ($urandom_range(9))
         0: kind = KIND_CMD;
         1: kind = KIND_ERROR;
         2, 3, 4: kind = KIND_TIMING;
         default: kind = KIND_DATA;
      endcase
      send_item(kind, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom), sec, nsec,
                48'({$urandom, $urandom}));
   endtask

   task automatic test_directed();
      send_item(KIND_DATA, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 32'hFFFF_FFFF, 30'h3FFF_FFFF, '0);
      send_item(KIND_DATA, 16'd0, 16'd0, 8'd0, 1'b0, 32'hFFFF_FFFF, 30'h3FFF_FFFF, '0);
      send_item(KIND_DATA, 16'd100, 16'd3, 8'd8, 1'b1, 32'd0, 30'd0, '0);
      send_item(KIND_DATA, 16'd100, 16'd3, 8'd8, 1'b1, 32'd0, 30'd0, '0);
      send_item(KIND_CMD, 16'hFFFF, 16'd0, 8'd0, 1'b0, 32'd0, 30'd0, '0);
      send_item(KIND_ERROR, 16'd12, 16'hFFFF, 8'hFF, 1'b1, 32'd5, 30'd5, '1);
      // two stamps, then a repeat of the newer one attaches its charge to the older
      send_item(KIND_TIMING, 16'd40, 16'd0, 8'd0, 1'b0, 32'd7, 30'd1, 48'sd1000);
      send_item(KIND_TIMING, 16'd40, 16'd0, 8'd0, 1'b0, 32'd7, 30'd2, 48'sd2000);
      send_item(KIND_TIMING, 16'd40, 16'd0, 8'd0, 1'b0, 32'd7, 30'd2, 48'h7FFF_FFFF_FFFF);
      send_item(KIND_DATA, 16'd8, 16'd1, 8'd4, 1'b0, 32'd7, 30'd1, '0);
      send_item(KIND_DATA, 16'd8, 16'd1, 8'd4, 1'b1, 32'd7, 30'd1, '0);
      // repeat at the oldest entry: nothing to attach to
      send_item(KIND_TIMING, 16'd40, 16'd0, 8'd0, 1'b0, 32'd7, 30'd1, 48'sd5);
      send_item(KIND_TIMING, 16'd40, 16'd0, 8'd0, 1'b0, 32'd9, 30'd0, 48'sd1);
      // negative charge clamps to zero and is still delivered
      send_item(KIND_TIMING, 16'd40, 16'd0, 8'd0, 1'b0, 32'd9, 30'd0, 48'h8000_0000_0000);
      send_item(KIND_TIMING, 16'd40, 16'd0, 8'd0, 1'b0, 32'd7, 30'd2, 48'sd1);
      send_item(KIND_DATA, 16'd1, 16'd1, 8'd1, 1'b0, 32'd7, 30'd2, '0);
      send_item(KIND_TIMING, 16'd40, 16'd0, 8'd0, 1'b0, 32'd9, 30'd0, 48'hFFFF_FFFF_FFFF);
   endtask

   task automatic test_random(int items, int idle);
      idle_pct = idle;
      refill_stamp_pool();
      repeat (items) send_random_item();
      idle_pct = 0;
   endtask

   task automatic test_cache_sizes();
      logic [4:0] sizes [8] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd31, 5'd3, 5'd16, 5'd10};
      int idles [4] = '{0, 51, 19, 0};
      foreach (sizes[i]) begin
         write_cache_size(sizes[i]);
         test_random(145, idles[i % 4]);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (counters[i]) counters[i] = '0;
      test_directed();
      test_cache_sizes();
      drain();
      if (mismatches == 0 && expected_stats.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
